FILE: rtl/core/hrp_pkg.sv
// Shared types, constants and helpers of the hex record halfword parser.
`default_nettype none

package hrp_pkg;

    localparam int          POS_W            = 10;
    localparam logic [9:0]  POS_MAX          = 10'd1023;
    localparam logic [9:0]  DATA_START       = 10'd9;
    localparam logic [31:0] FLASH_BASE_RESET = 32'h0800_0000;
    localparam logic [7:0]  HEX_ALPHA_BIAS   = 8'd55;

    // Work requested of the back end for one character.
    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_COUNT_HI,
        OP_COUNT_LO,
        OP_OFFSET,
        OP_DATA_ACC,
        OP_DATA_EMIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] nib;
    } cmd_t;

    // Hex digit to nibble; anything outside 0-9 / A-F maps to zero.
    function automatic logic [3:0] to_nibble(input logic [7:0] c);
        logic [7:0] diff;
        diff = c - HEX_ALPHA_BIAS;
        if (c >= "0" && c <= "9")
            return c[3:0];
        else if (c >= "A" && c <= "F")
            return diff[3:0];
        else
            return 4'd0;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hrp_ifs.sv
// Channel interfaces: character input, halfword results, configuration write.
`default_nettype none

interface hrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       record_start;
    modport source (output valid, output char_in, output record_start, input ready);
    modport sink   (input valid, input char_in, input record_start, output ready);
endinterface

interface hrp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] write_address;
    logic [15:0] halfword;
    logic [6:0]  word_index;
    logic        last_word;
    modport source (output valid, output write_address, output halfword,
                    output word_index, output last_word, input ready);
    modport sink   (input valid, input write_address, input halfword,
                    input word_index, input last_word, output ready);
endinterface

interface hrp_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] flash_base;
    modport source (output valid, output flash_base, input ready);
    modport sink   (input valid, input flash_base, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hrp_front.sv
// Front end: tracks character position and turns each character into a command.
`default_nettype none

module hrp_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    hrp_in_if.sink             chars,
    output hrp_pkg::cmd_t      cmd,
    output logic               cmd_valid,
    input  wire logic          cmd_ready
);

    logic [hrp_pkg::POS_W-1:0] pos_reg;
    logic [hrp_pkg::POS_W-1:0] pos_next;
    logic [hrp_pkg::POS_W-1:0] pos_inc;
    logic                      relevant;
    logic                      accept;

    assign chars.ready = cmd_ready;
    assign accept      = chars.valid && cmd_ready;
    assign pos_inc     = (pos_reg == hrp_pkg::POS_MAX) ? pos_reg : pos_reg + 1'b1;

    always_comb
    begin
        cmd.nib  = hrp_pkg::to_nibble(chars.char_in);
        cmd.op   = hrp_pkg::OP_DATA_ACC;
        relevant = 1'b1;
        if (chars.record_start)
        begin
            cmd.op = hrp_pkg::OP_CLEAR;
        end
        else if (pos_inc == 10'd1)
        begin
            cmd.op = hrp_pkg::OP_COUNT_HI;
        end
        else if (pos_inc == 10'd2)
        begin
            cmd.op = hrp_pkg::OP_COUNT_LO;
        end
        else if (pos_inc inside {[10'd3:10'd6]})
        begin
            cmd.op = hrp_pkg::OP_OFFSET;
        end
        else if (pos_inc >= hrp_pkg::DATA_START)
        begin
            // fourth digit of a group lands on a position that is a multiple of 4
            cmd.op = (pos_inc[1:0] == 2'b00) ? hrp_pkg::OP_DATA_EMIT : hrp_pkg::OP_DATA_ACC;
        end
        else
        begin
            relevant = 1'b0;   // record type field
        end
    end

    assign cmd_valid = chars.valid && relevant;

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
            pos_next = chars.record_start ? '0 : pos_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/hrp_cmd_fifo.sv
// Command queue between front and back ends.
`default_nettype none

module hrp_cmd_fifo #(
    parameter int DEPTH = 2
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire hrp_pkg::cmd_t push_cmd,
    input  wire logic          push_valid,
    output logic               push_ready,
    output hrp_pkg::cmd_t      pop_cmd,
    output logic               pop_valid,
    input  wire logic          pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hrp_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("command queue over capacity");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_W'(DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/hrp_back.sv
// Back end: record fields, halfword assembly and the result register.
`default_nettype none

module hrp_back
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire hrp_pkg::cmd_t cmd,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire logic [31:0]   flash_base,
    hrp_out_if.source          words
);

    logic [7:0]  count_reg,  count_next;
    logic [15:0] offset_reg, offset_next;
    logic [11:0] acc_reg,    acc_next;
    logic [6:0]  hw_cnt_reg, hw_cnt_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] addr_reg, addr_next;
    logic [15:0] hw_reg,   hw_next;
    logic [6:0]  idx_reg,  idx_next;
    logic        last_reg, last_next;

    logic        out_free;
    logic        pop;
    logic        in_data;

    assign out_free  = !out_valid_reg || words.ready;
    assign cmd_ready = (cmd.op != hrp_pkg::OP_DATA_EMIT) || out_free;
    assign pop       = cmd_valid && cmd_ready;
    assign in_data   = hw_cnt_reg < count_reg[7:1];

    always_comb
    begin
        count_next     = count_reg;
        offset_next    = offset_reg;
        acc_next       = acc_reg;
        hw_cnt_next    = hw_cnt_reg;
        out_valid_next = out_valid_reg && !words.ready;
        addr_next      = addr_reg;
        hw_next        = hw_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        if (pop)
        begin
            case (cmd.op)
                hrp_pkg::OP_CLEAR:
                begin
                    count_next  = '0;
                    offset_next = '0;
                    acc_next    = '0;
                    hw_cnt_next = '0;
                end
                hrp_pkg::OP_COUNT_HI: count_next  = {cmd.nib, 4'd0};
                hrp_pkg::OP_COUNT_LO: count_next  = {count_reg[7:4], count_reg[3:0] | cmd.nib};
                hrp_pkg::OP_OFFSET:   offset_next = {offset_reg[11:0], cmd.nib};
                hrp_pkg::OP_DATA_ACC:
                begin
                    if (in_data)
                        acc_next = {acc_reg[7:0], cmd.nib};
                end
                hrp_pkg::OP_DATA_EMIT:
                begin
                    if (in_data)
                    begin
                        out_valid_next = 1'b1;
                        addr_next      = flash_base | {16'd0, offset_reg};
                        hw_next        = {acc_reg, cmd.nib};
                        idx_next       = hw_cnt_reg;
                        last_next      = ({1'b0, hw_cnt_reg} + 8'd1) == {1'b0, count_reg[7:1]};
                        acc_next       = '0;
                        hw_cnt_next    = hw_cnt_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            offset_reg    <= '0;
            acc_reg       <= '0;
            hw_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            offset_reg    <= offset_next;
            acc_reg       <= acc_next;
            hw_cnt_reg    <= hw_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        hw_reg   <= hw_next;
        idx_reg  <= idx_next;
        last_reg <= last_next;
    end

    assign words.valid         = out_valid_reg;
    assign words.write_address = addr_reg;
    assign words.halfword      = hw_reg;
    assign words.word_index    = idx_reg;
    assign words.last_word     = last_reg;

`ifndef ASSERT_OFF
    a_hw_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hw_cnt_reg <= count_reg[7:1])
        else $error("halfword count beyond byte count");
    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cmd.op == hrp_pkg::OP_DATA_EMIT) |-> out_free)
        else $error("emit popped with result register busy");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/hex_record_halfword_parser_unit.sv
// Top level of the hex record halfword parser.
`default_nettype none

// Takes one ASCII character per request on "chars" (record_start marks the
// colon) and returns one request on "words" per completed data halfword:
// flash_base OR the record offset, the halfword (first digit most
// significant), its index in the record and a last flag. The record type,
// checksum and any trailing odd byte are ignored; non-hex characters count
// as zero. A new character is taken every cycle while the command queue has
// room. The front end assigns positions and classifies each character, a
// QUEUE_DEPTH-entry command queue decouples it from the back end, which
// updates the record fields and holds the result in an output register.
// While the output is stalled only halfword-completing commands wait, so
// the queue absorbs up to QUEUE_DEPTH commands before "chars" deasserts
// ready. flash_base is written on "cfg" (always ready) and should only
// change while the unit is idle.
module hex_record_halfword_parser_unit #(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    hrp_in_if.sink    chars,
    hrp_out_if.source words,
    hrp_cfg_if.sink   cfg
);

    logic [31:0]   flash_base_reg;
    logic [31:0]   flash_base_next;

    hrp_pkg::cmd_t front_cmd;
    logic          front_valid;
    logic          front_ready;
    hrp_pkg::cmd_t back_cmd;
    logic          back_valid;
    logic          back_ready;

    // config register
    assign cfg.ready       = 1'b1;
    assign flash_base_next = (cfg.valid) ? cfg.flash_base : flash_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flash_base_reg <= hrp_pkg::FLASH_BASE_RESET;
        else
            flash_base_reg <= flash_base_next;
    end

    hrp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    hrp_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_cmd    (back_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    hrp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (back_cmd),
        .cmd_valid  (back_valid),
        .cmd_ready  (back_ready),
        .flash_base (flash_base_reg),
        .words      (words)
    );

`ifndef ASSERT_OFF
    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid |=> (flash_base_reg == $past(cfg.flash_base)))
        else $error("flash_base write lost");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_hex_record_halfword_parser_unit.sv
// Self-checking testbench for the hex record halfword parser unit.
`timescale 1ns / 1ps

module tb_hex_record_halfword_parser_unit;

    // Cycles without any accepted request before the run is declared hung.
    localparam int HANG_LIMIT   = 2000;
    // Cycles to let queued non-emitting commands drain after the last result.
    localparam int SETTLE_TICKS = 8;
    // Random characters per idle phase (about 550 in all with the directed rows).
    localparam int PHASE_CHARS  = 115;
    localparam int NUM_PHASES   = 4;

    // One halfword result as it leaves the unit.
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] hw;
        logic [6:0]  idx;
        logic        last;
    } word_t;

    // One directed stimulus row; own marks a row whose result is typed in.
    typedef struct {
        logic [7:0] c;
        logic       s;
        bit         own;
        word_t      w;
    } row_t;

    logic clk;
    logic rst_n;

    hrp_in_if  chars_if ();
    hrp_out_if words_if ();
    hrp_cfg_if cfg_if ();

    hex_record_halfword_parser_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars_if),
        .words (words_if),
        .cfg   (cfg_if)
    );

    // Sideband that travels with each character request: a typed-in result
    // replaces the predicted one for that character.
    bit    own_tag;
    word_t own_word;

    // Parser model state, reset values as after a start character.
    logic [31:0] base_model = hrp_pkg::FLASH_BASE_RESET;
    logic [9:0]  m_pos      = '0;
    logic [7:0]  m_count    = '0;
    logic [15:0] m_offset   = '0;
    logic [11:0] m_acc      = '0;
    logic [6:0]  m_hw       = '0;

    word_t expected_words [$];

    int errors      = 0;
    int quiet       = 0;
    int chars_sent  = 0;
    int words_seen  = 0;
    int bases_used  = 1;
    int send_idle   = 0;
    int recv_stall  = 0;

    row_t plan [28];

    // Clock: 2 ns period.
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: random back-pressure at the rate of the current phase.
    initial begin
        words_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            words_if.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // ASCII value of a hex digit, upper case.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
    endfunction

    // Mostly hex digits, now and then any byte (lower case, controls, 8'hFF).
    function automatic logic [7:0] data_char();
        if ($urandom_range(99) < 85)
            return hex_char(4'($urandom_range(15)));
        return 8'($urandom_range(255));
    endfunction

    // Nibble of a character; non-hex characters give zero.
    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= "0" && c <= "9")
            d = c - "0";
        else if (c >= "A" && c <= "F")
            d = c - "A" + 8'd10;
        return d[3:0];
    endfunction

    // Advance the parser model by one character; returns 1 when a halfword
    // completes, with the expected result in w.
    function automatic bit predict_char(input logic [7:0] c, input logic s,
                                        output word_t w);
        logic [3:0] nib;
        logic [9:0] rel;
        w = '0;
        if (s)
        begin
            // start character only clears the record, whatever it is
            m_pos    = '0;
            m_count  = '0;
            m_offset = '0;
            m_acc    = '0;
            m_hw     = '0;
            return 1'b0;
        end
        if (m_pos < hrp_pkg::POS_MAX)
            m_pos = m_pos + 10'd1;
        nib = digit_value(c);
        rel = m_pos - hrp_pkg::DATA_START;
        if (m_pos == 10'd1)
            m_count = {nib, 4'h0};
        else if (m_pos == 10'd2)
            m_count = m_count | {4'h0, nib};
        else if (m_pos >= 10'd3 && m_pos <= 10'd6)
            m_offset = {m_offset[11:0], nib};
        else if (m_pos >= hrp_pkg::DATA_START && m_hw < m_count[7:1])
        begin
            // positions 7-8 (record type) fall through untouched
            if (rel[1:0] != 2'd3)
                m_acc = {m_acc[7:0], nib};
            else
            begin
                w.addr = base_model | {16'h0000, m_offset};
                w.hw   = {m_acc, nib};
                w.idx  = m_hw;
                w.last = (m_hw + 7'd1 == m_count[7:1]);
                m_acc  = '0;
                m_hw   = m_hw + 7'd1;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Scoreboard: predicts on every accepted character, checks every accepted
    // halfword against the oldest expectation, tracks base writes and hangs.
    always @(posedge clk)
    begin : scoreboard
        word_t want;
        word_t got;
        word_t pred;
        bit    fresh;
        bit    busy;
        busy = 1'b0;
        if (rst_n)
        begin
            if (words_if.valid && words_if.ready)
            begin
                busy = 1'b1;
                got  = '{words_if.write_address, words_if.halfword,
                         words_if.word_index, words_if.last_word};
                if (expected_words.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected halfword, expected none, actual %h", $time, got);
                end
                else
                begin
                    want = expected_words.pop_front();
                    words_seen++;
                    if (got.addr !== want.addr)
                    begin
                        errors++;
                        $display("%0t: write_address expected %h actual %h",
                                 $time, want.addr, got.addr);
                    end
                    if (got.hw !== want.hw)
                    begin
                        errors++;
                        $display("%0t: halfword expected %h actual %h",
                                 $time, want.hw, got.hw);
                    end
                    if (got.idx !== want.idx)
                    begin
                        errors++;
                        $display("%0t: word_index expected %0d actual %0d",
                                 $time, want.idx, got.idx);
                    end
                    if (got.last !== want.last)
                    begin
                        errors++;
                        $display("%0t: last_word expected %b actual %b",
                                 $time, want.last, got.last);
                    end
                end
            end
            if (chars_if.valid && chars_if.ready)
            begin
                busy  = 1'b1;
                fresh = predict_char(chars_if.char_in, chars_if.record_start, pred);
                if (own_tag)
                    expected_words.push_back(own_word);
                else if (fresh)
                    expected_words.push_back(pred);
            end
            if (cfg_if.valid && cfg_if.ready)
            begin
                busy       = 1'b1;
                base_model = cfg_if.flash_base;
            end
            if (busy)
                quiet = 0;
            else
            begin
                quiet++;
                if (quiet >= HANG_LIMIT)
                begin
                    $display("%0t: no request accepted for %0d cycles", $time, quiet);
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    // Present one character and hold it until accepted. Valid stays high on
    // return so back-to-back requests need no extra assignment.
    task automatic send_char(input logic [7:0] c, input logic s,
                             input bit own, input word_t w);
        while ($urandom_range(99) < send_idle)
        begin
            chars_if.valid <= 1'b0;
            @(posedge clk);
        end
        chars_if.valid        <= 1'b1;
        chars_if.char_in      <= c;
        chars_if.record_start <= s;
        own_tag               <= own;
        own_word              <= w;
        do
            @(posedge clk);
        while (!chars_if.ready);
        chars_sent++;
    endtask

    // Sender pauses until every expected halfword has come back, then lets
    // queued non-emitting commands drain. The first edge lets the scoreboard
    // record the last accepted character before the queue is looked at.
    task automatic wait_for_results();
        chars_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_base(input logic [31:0] v);
        cfg_if.valid      <= 1'b1;
        cfg_if.flash_base <= v;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        bases_used++;
    endtask

    // One record: mostly well formed with random content; some lack the
    // start flag, some are cut short, some carry trailing junk.
    task automatic send_record();
        int nbytes;
        int nchars;
        int cut;
        int extra;
        int pick;
        logic [7:0] cnt;
        pick = $urandom_range(99);
        if (pick < 70)
            nbytes = $urandom_range(8);
        else if (pick < 98)
            nbytes = $urandom_range(40, 9);
        else
            nbytes = $urandom_range(255, 41);
        cnt = 8'(nbytes);
        if ($urandom_range(99) < 92)
            send_char(($urandom_range(7) == 0) ? 8'($urandom_range(255)) : ":",
                      1'b1, 1'b0, '0);
        send_char(($urandom_range(99) < 3) ? data_char() : hex_char(cnt[7:4]),
                  1'b0, 1'b0, '0);
        send_char(($urandom_range(99) < 3) ? data_char() : hex_char(cnt[3:0]),
                  1'b0, 1'b0, '0);
        // offset and record type
        repeat (6) send_char(data_char(), 1'b0, 1'b0, '0);
        nchars = 4 * (nbytes / 2) + 2 * (nbytes % 2) + 2;
        cut    = ($urandom_range(99) < 10) ? $urandom_range(nchars) : nchars;
        repeat (cut) send_char(data_char(), 1'b0, 1'b0, '0);
        extra = ($urandom_range(99) < 15) ? $urandom_range(4, 1) : 0;
        repeat (extra) send_char(data_char(), 1'b0, 1'b0, '0);
    endtask

    initial begin : stimulus
        int          idle_mix  [NUM_PHASES];
        int          stall_mix [NUM_PHASES];
        logic [31:0] base_seq  [NUM_PHASES];
        int          mark;
        idle_mix  = '{0, 79, 0, 33};
        stall_mix = '{0, 0, 79, 33};
        base_seq  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'($urandom), 32'($urandom)};

        // Directed rows. Record one follows reset with no start flag; the
        // second is abandoned by a new start after one character; the third
        // has an odd byte count, non-hex digits and extreme byte values.
        plan = '{
            '{"0", 1'b0, 1'b0, '0}, '{"2", 1'b0, 1'b0, '0},
            '{"1", 1'b0, 1'b0, '0}, '{"2", 1'b0, 1'b0, '0},
            '{"3", 1'b0, 1'b0, '0}, '{"4", 1'b0, 1'b0, '0},
            '{"0", 1'b0, 1'b0, '0}, '{"0", 1'b0, 1'b0, '0},
            '{"A", 1'b0, 1'b0, '0}, '{"B", 1'b0, 1'b0, '0},
            '{"C", 1'b0, 1'b0, '0},
            '{"D", 1'b0, 1'b1, '{32'h0800_1234, 16'hABCD, 7'd0, 1'b1}},
            '{":", 1'b1, 1'b0, '0}, '{"4", 1'b0, 1'b0, '0},
            '{8'h00, 1'b1, 1'b0, '0},
            '{"0", 1'b0, 1'b0, '0}, '{"3", 1'b0, 1'b0, '0},
            '{"F", 1'b0, 1'b0, '0}, '{"F", 1'b0, 1'b0, '0},
            '{"F", 1'b0, 1'b0, '0}, '{"F", 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
            '{"f", 1'b0, 1'b0, '0}, '{"9", 1'b0, 1'b0, '0},
            '{"a", 1'b0, 1'b0, '0},
            '{"0", 1'b0, 1'b1, '{32'h0800_FFFF, 16'h0900, 7'd0, 1'b1}},
            '{"G", 1'b0, 1'b0, '0}
        };

        // Every input known from time zero.
        rst_n                 <= 1'b0;
        chars_if.valid        <= 1'b0;
        chars_if.char_in      <= 8'h00;
        chars_if.record_start <= 1'b0;
        cfg_if.valid          <= 1'b0;
        cfg_if.flash_base     <= 32'h0000_0000;
        own_tag               <= 1'b0;
        own_word              <= '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at full rate with the reset base address.
        foreach (plan[i])
            send_char(plan[i].c, plan[i].s, plan[i].own, plan[i].w);
        wait_for_results();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // Base address changes only with the unit idle.
            wait_for_results();
            send_idle  = idle_mix[p];
            recv_stall = stall_mix[p];
            write_base(base_seq[p]);
            mark = chars_sent;
            while (chars_sent - mark < PHASE_CHARS)
            begin
                send_record();
                if ($urandom_range(19) == 0)
                    wait_for_results();
            end
        end

        // Drain: the watchdog bounds this wait.
        wait_for_results();
        if (expected_words.size() != 0)
            errors++;

        $display("Sent %0d characters, checked %0d halfwords over %0d base settings;",
                 chars_sent, words_seen, bases_used);
        $display("idle mixes: none, sender only, receiver only, both; %0d errors.", errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
